### hw/rtl/fixed_partition_allocator_core_assert.svh
// assertion macros used by the allocator rtl
`ifndef FIXED_PARTITION_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_PARTITION_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpa check failed: same-cycle implication");

// next-cycle implication, held off during reset
`define FPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fpa check failed: next-cycle implication");

`endif

### hw/rtl/fpa_pkg.sv
package fpa_pkg;

    localparam int SLOT_MAX       = 6;
    localparam int FPA_PARTITIONS = 6;

    localparam int PID_W   = 10;
    localparam int SIZE_W  = 8;
    localparam int PNUM_W  = 3;
    localparam int SUM_W   = 11;
    localparam int TOTAL_W = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_MEMORY = CFG_IDX_W'(SLOT_MAX);

    localparam logic [SIZE_W-1:0] SIZE_RESET [SLOT_MAX] =
        '{8'd40, 8'd25, 8'd15, 8'd10, 8'd8, 8'd2};
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 10'd100;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [PID_W-1:0]  process_id;
        logic [SIZE_W-1:0] request_size;
    } t_req;

    typedef struct packed {
        logic                granted;
        logic [PNUM_W-1:0]   partition_number;
        logic [SUM_W-1:0]    used_mem;
        logic [TOTAL_W-1:0]  free_mem;
        logic [SUM_W-1:0]    open_mem;
        logic [SLOT_MAX-1:0] occupied_mask;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg;

endpackage

### hw/rtl/fpa_if.sv
interface fpa_req_if import fpa_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpa_cfg_if import fpa_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/fixed_partition_allocator_core.sv
// fixed partition allocator
// i_req carries one request word: func (allocate or release), process_id and
// request_size. an allocate takes the highest numbered free partition that is
// large enough; a release frees the lowest numbered partition held by the id.
// o_rsp returns one word per request: granted, partition number and the
// occupancy figures after the request has been applied.
// i_cfg writes the partition sizes (index 0 to 5) and total memory (index 6); it is
// ready whenever out of reset. the user must write i_cfg only while no request is
// in flight; the block does not enforce this. a request is taken into an input
// register, then the search, state update and sums are combinational into the
// result register, which drives o_rsp; one word per cycle is sustained while
// o_rsp.ready stays high.
// when o_rsp stalls, the result register holds and the input register still
// takes one more word; i_req.ready drops once both are full.
// reset clears the occupancy of every partition and loads the default sizes
// 40, 25, 15, 10, 8, 2 and a total of 100; both ready lines are low in reset.
module fixed_partition_allocator_core
    import fpa_pkg::*;
#(
    parameter int PARTITIONS = FPA_PARTITIONS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpa_req_if.sink    i_req,
    fpa_rsp_if.source  o_rsp,
    fpa_cfg_if.sink    i_cfg
);

    logic                r_in_valid;
    t_req                r_in;
    logic                r_out_valid;
    t_rsp                r_out;

    logic [SIZE_W-1:0]   r_size [PARTITIONS];
    logic [TOTAL_W-1:0]  r_total;

    logic [PARTITIONS-1:0] r_busy;
    logic [PID_W-1:0]      r_owner   [PARTITIONS];
    logic [SIZE_W-1:0]     r_request [PARTITIONS];

    logic [PARTITIONS-1:0] n_busy;
    t_rsp                  n_out;
    logic                  found;
    logic [PNUM_W-1:0]     hit;
    logic                  move;
    logic                  in_accept;

    assign move      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_accept = i_req.valid && i_req.ready;

    assign i_req.ready = i_rst_n && (!r_in_valid || move);
    assign i_cfg.ready = i_rst_n;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // slot search and state update
    always_comb begin
        n_busy = r_busy;
        found  = 1'b0;
        hit    = '0;
        if (r_in.func == FUNC_ALLOC) begin
            for (int i = PARTITIONS - 1; i >= 0; i--) begin
                if (!found && !r_busy[i] && r_size[i] >= r_in.request_size) begin
                    found = 1'b1;
                    hit   = PNUM_W'(i);
                end
            end
            if (found) begin
                n_busy[hit] = 1'b1;
            end
        end else begin
            for (int i = 0; i < PARTITIONS; i++) begin
                if (!found && r_busy[i] && r_owner[i] == r_in.process_id) begin
                    found = 1'b1;
                    hit   = PNUM_W'(i);
                end
            end
            if (found) begin
                n_busy[hit] = 1'b0;
            end
        end
    end

    // occupancy figures after the update
    always_comb begin
        n_out = '0;
        n_out.granted          = found;
        n_out.partition_number = found ? PNUM_W'(hit + 1'b1) : '0;
        for (int i = 0; i < PARTITIONS; i++) begin
            if (n_busy[i]) begin
                if (found && r_in.func == FUNC_ALLOC && hit == PNUM_W'(i)) begin
                    n_out.used_mem = n_out.used_mem + SUM_W'(r_in.request_size);
                end else begin
                    n_out.used_mem = n_out.used_mem + SUM_W'(r_request[i]);
                end
                n_out.occupied_mask[i] = 1'b1;
            end else begin
                n_out.open_mem = n_out.open_mem + SUM_W'(r_size[i]);
            end
        end
        if (SUM_W'(r_total) > n_out.used_mem) begin
            n_out.free_mem = TOTAL_W'(SUM_W'(r_total) - n_out.used_mem);
        end else begin
            n_out.free_mem = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            r_total     <= TOTAL_RESET;
            for (int i = 0; i < PARTITIONS; i++) begin
                r_size[i] <= SIZE_RESET[i];
            end
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_busy      <= n_busy;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                for (int i = 0; i < PARTITIONS; i++) begin
                    if (i_cfg.data.index == CFG_IDX_W'(i)) begin
                        r_size[i] <= i_cfg.data.value[SIZE_W-1:0];
                    end
                end
                if (i_cfg.data.index == CFG_TOTAL_MEMORY) begin
                    r_total <= i_cfg.data.value[TOTAL_W-1:0];
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_req.data;
        end
        if (move) begin
            r_out <= n_out;
            if (found && r_in.func == FUNC_ALLOC) begin
                r_owner[hit]   <= r_in.process_id;
                r_request[hit] <= r_in.request_size;
            end
        end
    end

`include "fixed_partition_allocator_core_assert.svh"

    `FPA_ASSERT_IMP(a_pnum_matches_grant, i_clk, i_rst_n, r_out_valid,
        (r_out.granted == (r_out.partition_number != '0)))
    `FPA_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_in_valid && !move, !in_accept)
    `FPA_ASSERT_NEXT(a_alloc_adds_one, i_clk, i_rst_n,
        move && found && r_in.func == FUNC_ALLOC,
        $countones(r_busy) == $countones($past(r_busy)) + 1)

endmodule
